### rtl/pst_pkg.sv
// Package for the polar scan to cartesian block: shared types, codes and the CORDIC
// angle table. Used by the controller, the datapath and the top level.
// No dependencies.
package pst_pkg;

    // Widths fixed by the channel fields
    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int POINT_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Step index covers up to 24 micro-rotations
    localparam int STEP_W   = 5;
    localparam int ATAN_W   = 30;

    // Inverse CORDIC gain, Q30
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    // Output saturation limit in mm
    localparam int OUT_LIMIT = 65535;

    typedef enum logic [1:0] {
        KIND_SKIP   = 2'd0,
        KIND_RETURN = 2'd1,
        KIND_MISS   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_RANGE  = 3'd0,
        REG_MAX_RANGE  = 3'd1,
        REG_MISS_RAY   = 3'd2,
        REG_START_ANG  = 3'd3,
        REG_ANGLE_STEP = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ROT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              ready;
        logic              mul;
        logic              rot;
        logic [STEP_W-1:0] step;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_dp_sts;

    // round(atan(2^-i) * 2^32 / (2*pi))
    function automatic logic [ATAN_W-1:0] atan_at(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/pst_ifs.sv
// Channel interfaces for the polar scan to cartesian block: sample input, point output
// and configuration write. Depends on pst_pkg for field widths.
interface pst_in_if;
    logic                          valid;
    logic                          ready;
    logic [pst_pkg::RANGE_W-1:0]   echo_range;
    logic                          echo_present;
    logic                          echo_invalid;
    logic                          last_of_scan;

    modport source (output valid, echo_range, echo_present, echo_invalid, last_of_scan,
                    input ready);
    modport sink   (input valid, echo_range, echo_present, echo_invalid, last_of_scan,
                    output ready);
endinterface

interface pst_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         point_kind;
    logic signed [pst_pkg::POINT_W-1:0] point_x;
    logic signed [pst_pkg::POINT_W-1:0] point_y;
    logic                               scan_end;

    modport source (output valid, point_kind, point_x, point_y, scan_end, input ready);
    modport sink   (input valid, point_kind, point_x, point_y, scan_end, output ready);
endinterface

interface pst_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pst_pkg::CFG_IDX_W-1:0]   index;
    logic [pst_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pst_ctrl.sv
// Sequencer for the polar scan to cartesian block: walks each sample through gain
// multiply, CORDIC micro-rotations and output load. Depends on pst_pkg.
module pst_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pst_pkg::t_dp_sts i_sts,
    output pst_pkg::t_dp_cmd o_cmd
);

    localparam logic [pst_pkg::STEP_W-1:0] LAST_STEP = pst_pkg::STEP_W'(CORDIC_STEPS - 1);

    pst_pkg::t_state             r_state, n_state;
    logic [pst_pkg::STEP_W-1:0]  r_step,  n_step;
    logic                        out_go;

    assign out_go = (r_state == pst_pkg::S_OUT) && i_sts.out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            pst_pkg::S_IDLE: begin
                if (i_sts.in_valid) n_state = pst_pkg::S_MUL;
            end
            pst_pkg::S_MUL: begin
                n_state = pst_pkg::S_ROT;
                n_step  = '0;
            end
            pst_pkg::S_ROT: begin
                if (r_step == LAST_STEP) begin
                    n_state = pst_pkg::S_OUT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            pst_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.in_valid ? pst_pkg::S_MUL : pst_pkg::S_IDLE;
                end
            end
            default: n_state = pst_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.step  = r_step;
        unique case (r_state)
            pst_pkg::S_IDLE: o_cmd.ready = 1'b1;
            pst_pkg::S_MUL:  o_cmd.mul   = 1'b1;
            pst_pkg::S_ROT:  o_cmd.rot   = 1'b1;
            pst_pkg::S_OUT: begin
                o_cmd.emit  = out_go;
                o_cmd.ready = out_go;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pst_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef ASSERT_OFF
    a_mul_to_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pst_pkg::S_MUL |=> (r_state == pst_pkg::S_ROT && r_step == '0))
        else $error("multiply not followed by first rotation step");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pst_pkg::S_ROT |-> r_step <= LAST_STEP)
        else $error("rotation step beyond last");

    a_rot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pst_pkg::S_ROT && r_step == LAST_STEP) |=> r_state == pst_pkg::S_OUT)
        else $error("rotation did not finish into output load");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pst_pkg::S_OUT && !i_sts.out_free) |=> r_state == pst_pkg::S_OUT)
        else $error("result dropped while output register busy");
`endif

endmodule

### rtl/pst_datapath.sv
// Datapath for the polar scan to cartesian block: configuration registers, angle
// accumulator, gain multiply, CORDIC rotator and output register. Depends on pst_pkg
// and the channel interfaces.
module pst_datapath #(
    parameter int RANGE_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    pst_in_if.sink           i_in,
    pst_out_if.source        o_out,
    pst_cfg_if.sink          i_cfg,
    input  pst_pkg::t_dp_cmd i_cmd,
    output pst_pkg::t_dp_sts o_sts
);

    localparam int CMP_W  = ((RANGE_BITS > pst_pkg::RANGE_W) ? RANGE_BITS : pst_pkg::RANGE_W) + 1;
    localparam int PROD_W = RANGE_BITS + pst_pkg::ATAN_W;
    localparam int R_W    = RANGE_BITS + 17;
    localparam int X_W    = RANGE_BITS + 18;
    localparam int Z_W    = 33;
    localparam int Q_W    = (X_W - 15 > pst_pkg::POINT_W + 1) ? X_W - 15 : pst_pkg::POINT_W + 1;
    localparam logic [CMP_W-1:0] LEN_LIM = CMP_W'((64'd1 << RANGE_BITS) - 64'd1);
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(pst_pkg::OUT_LIMIT);
    localparam logic signed [Q_W-1:0] SAT_LO = -Q_W'(pst_pkg::OUT_LIMIT);

    // Configuration registers
    logic [pst_pkg::CFG_DAT_W-1:0] r_min_range, r_max_range, r_miss_ray;
    logic [pst_pkg::ANGLE_W-1:0]   r_start_ang, r_angle_step, r_offset;

    // Working registers
    logic [RANGE_BITS-1:0]   r_len;
    logic [1:0]              r_quad;
    logic signed [X_W-1:0]   r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    pst_pkg::t_kind          r_kind;
    logic                    r_last;

    // Output register
    logic                                r_out_valid;
    pst_pkg::t_kind                      r_out_kind;
    logic signed [pst_pkg::POINT_W-1:0]  r_out_x, r_out_y;
    logic                                r_out_last;

    logic                          acc;
    logic [pst_pkg::ANGLE_W-1:0]   angle;
    pst_pkg::t_kind                n_kind;
    logic [pst_pkg::RANGE_W-1:0]   src;
    logic [CMP_W-1:0]              src_ext;
    logic [RANGE_BITS-1:0]         n_len;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W:0]               prod_rnd;
    logic signed [X_W-1:0]         r_scaled;
    logic signed [X_W-1:0]         x0, y0, dx, dy;
    logic signed [Z_W-1:0]         atan_s;
    logic signed [pst_pkg::POINT_W-1:0] fx, fy;

    assign acc          = i_in.valid && i_cmd.ready;
    assign i_in.ready   = i_cmd.ready;
    assign i_cfg.ready  = 1'b1;
    assign o_sts.in_valid = i_in.valid;
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    // Sample classification and length selection
    assign angle = r_start_ang + r_offset;

    always_comb begin
        n_kind = pst_pkg::KIND_SKIP;
        src    = i_in.echo_range;
        if (i_in.echo_present && !i_in.echo_invalid && i_in.echo_range >= r_min_range) begin
            if (i_in.echo_range <= r_max_range) begin
                n_kind = pst_pkg::KIND_RETURN;
            end else begin
                n_kind = pst_pkg::KIND_MISS;
                src    = r_miss_ray;
            end
        end
        src_ext = CMP_W'(src);
        n_len   = (src_ext > LEN_LIM) ? RANGE_BITS'(LEN_LIM) : RANGE_BITS'(src_ext);
    end

    // Gain compensation and quadrant placement
    always_comb begin
        prod     = PROD_W'(r_len) * PROD_W'(pst_pkg::GAIN_Q30);
        prod_rnd = (PROD_W + 1)'(prod) + (PROD_W + 1)'(8192);
        r_scaled = signed'(X_W'(R_W'(prod_rnd >> 14)));
        case (r_quad)
            2'd0:    begin x0 = r_scaled;  y0 = '0;        end
            2'd1:    begin x0 = '0;        y0 = r_scaled;  end
            2'd2:    begin x0 = -r_scaled; y0 = '0;        end
            default: begin x0 = '0;        y0 = -r_scaled; end
        endcase
    end

    // One micro-rotation
    assign dx     = r_y >>> i_cmd.step;
    assign dy     = r_x >>> i_cmd.step;
    assign atan_s = signed'(Z_W'(pst_pkg::atan_at(i_cmd.step)));

    // Round half up to whole mm and saturate
    function automatic logic signed [pst_pkg::POINT_W-1:0] finish(
        input logic signed [X_W-1:0] v
    );
        logic signed [X_W:0]   s;
        logic signed [Q_W-1:0] q;
        s = (X_W + 1)'(v) + (X_W + 1)'(32768);
        q = Q_W'(s >>> 16);
        if (q > SAT_HI) q = SAT_HI;
        if (q < SAT_LO) q = SAT_LO;
        return pst_pkg::POINT_W'(q);
    endfunction

    assign fx = (r_kind == pst_pkg::KIND_SKIP) ? '0 : finish(r_x);
    assign fy = (r_kind == pst_pkg::KIND_SKIP) ? '0 : finish(r_y);

    // Configuration and angle accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range  <= 16'd0;
            r_max_range  <= 16'd65535;
            r_miss_ray   <= 16'd5000;
            r_start_ang  <= 16'd0;
            r_angle_step <= 16'd64;
            r_offset     <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    pst_pkg::REG_MIN_RANGE:  r_min_range  <= i_cfg.data;
                    pst_pkg::REG_MAX_RANGE:  r_max_range  <= i_cfg.data;
                    pst_pkg::REG_MISS_RAY:   r_miss_ray   <= i_cfg.data;
                    pst_pkg::REG_START_ANG:  r_start_ang  <= i_cfg.data;
                    pst_pkg::REG_ANGLE_STEP: r_angle_step <= i_cfg.data;
                    default: ;
                endcase
            end
            if (acc) begin
                r_offset <= i_in.last_of_scan ? '0 : r_offset + r_angle_step;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_len  <= n_len;
            r_quad <= angle[15:14];
            r_z    <= signed'(Z_W'({angle[13:0], 16'b0}));
            r_kind <= n_kind;
            r_last <= i_in.last_of_scan;
        end
        if (i_cmd.mul) begin
            r_x <= x0;
            r_y <= y0;
        end
        if (i_cmd.rot) begin
            if (!r_z[Z_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_s;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_s;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= r_kind;
            r_out_x    <= fx;
            r_out_y    <= fy;
            r_out_last <= r_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.point_kind = r_out_kind;
    assign o_out.point_x    = r_out_x;
    assign o_out.point_y    = r_out_y;
    assign o_out.scan_end   = r_out_last;

endmodule

### rtl/polar_scan_to_cartesian.sv
// Polar scan to cartesian: one range sample in, one 2-D point out per transfer.
// Each sample passes through the gain multiply, the CORDIC micro-rotations and the output
// register in turn; only one sample is in work at a time, set by the single shared CORDIC
// rotator that does one micro-rotation per cycle; the next sample is taken as the
// finished point moves into the output register. Reset is synchronous, active low:
// registers return to their defaults, the angle offset clears and the output empties.
module polar_scan_to_cartesian #(
    parameter int CORDIC_STEPS = 16,
    parameter int RANGE_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pst_in_if.sink     i_in,
    pst_out_if.source  o_out,
    pst_cfg_if.sink    i_cfg
);

    // Command and status between sequencer and datapath
    pst_pkg::t_dp_cmd cmd;
    pst_pkg::t_dp_sts sts;

    // Sequencer: idle, gain multiply, rotate, load output
    pst_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Datapath: config, angle accumulator, rotator, output register
    pst_datapath #(
        .RANGE_BITS (RANGE_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
